// ===== rtl/tssmg_pkg.sv =====
// Shared constants for the tilt/shake/spin motion generator.
package tssmg_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TILT_RATE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_RATE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_AMP      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_AMP     = 3'd6;

   localparam logic [31:0] RST_TILT_RATE     = 32'd22369621;
   localparam logic [31:0] RST_SHAKE_RATE    = 32'd38347922;
   localparam logic [31:0] RST_SPIN_RATE     = 32'd31956602;
   localparam logic [15:0] RST_SHAKE_GAIN    = 16'd8192;
   localparam logic [23:0] RST_GRAVITY_SCALE = 24'd2511360;
   localparam logic [23:0] RST_SPIN_AMP      = 24'd65536;
   localparam logic [23:0] RST_ALPHA_AMP     = 24'd49019;

   // quarter-wave sine polynomial coefficients
   localparam logic [16:0] SIN_A = 17'd51472;
   localparam logic [16:0] SIN_B = 17'd21025;
   localparam logic [15:0] SIN_C = 16'd2320;
   localparam logic [16:0] SIN_MAX = 17'd32767;

   // renormalize only above 0.1 in Q15
   localparam logic [17:0] NORM_MIN = 18'd3277;

   localparam int unsigned MUL_AW = 32;
   localparam int unsigned MUL_BW = 18;

   localparam int unsigned SQ_W   = 36;
   localparam int unsigned ROOT_W = 18;
   localparam int unsigned NUM_W  = 33;

endpackage

// ===== rtl/tssmg_mul.sv =====
// Bit-serial shift-and-add unsigned multiplier, one multiplier bit per cycle.
module tssmg_mul #(
   parameter int unsigned AW = 32,
   parameter int unsigned BW = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);
   localparam int unsigned CW = (BW > 1) ? $clog2(BW) : 1;

   logic [AW+BW-1:0] prod_ff, prod_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW:0]      sum;

   assign sum = {1'b0, prod_ff[AW+BW-1:BW]} + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      prod_in = prod_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         prod_in = {{AW{1'b0}}, b};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[BW-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;
endmodule

// ===== rtl/tssmg_sine.sv =====
// Q1.15 sine of a 16-bit turn angle, polynomial evaluated on a serial multiplier.
module tssmg_sine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [15:0] sine
);
   import tssmg_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SQ   = 5'b00010,
      S_C    = 5'b00100,
      S_B    = 5'b01000,
      S_A    = 5'b10000
   } sine_state_type;

   sine_state_type state_ff, state_in;
   logic [15:0] x_ff, x_in, x2_ff, x2_in, mid_ff, mid_in;
   logic [14:0] inner_ff, inner_in;
   logic        neg_ff, neg_in;
   logic signed [15:0] sine_ff, sine_in;
   logic        done_ff, done_in;
   logic        go_ff, go_in;
   logic [15:0] ma, mb;
   logic        m_done;
   logic [31:0] m_prod;
   logic [14:0] frac;
   logic [16:0] y;

   tssmg_mul #(.AW(16), .BW(16)) u_mul (
      .clock(clock), .reset(reset), .start(go_ff), .a(ma), .b(mb),
      .done(m_done), .product(m_prod)
   );

   assign frac = {angle[13:0], 1'b0};
   assign y    = (m_prod[31:15] > SIN_MAX) ? SIN_MAX : m_prod[31:15];

   always_comb begin
      unique case (state_ff)
         S_SQ:    begin ma = x_ff;  mb = x_ff;   end
         S_C:     begin ma = x2_ff; mb = SIN_C;  end
         S_B:     begin ma = x2_ff; mb = {1'b0, inner_ff}; end
         S_A:     begin ma = x_ff;  mb = mid_ff; end
         default: begin ma = '0;    mb = '0;     end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      inner_in = inner_ff;
      mid_in   = mid_ff;
      neg_in   = neg_ff;
      sine_in  = sine_ff;
      done_in  = 1'b0;
      go_in    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // mirror odd quadrants, negate the second half turn
               x_in     = angle[14] ? 16'(17'd32768 - {2'b0, frac}) : {1'b0, frac};
               neg_in   = angle[15];
               go_in    = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (m_done) begin
               x2_in    = m_prod[30:15];
               go_in    = 1'b1;
               state_in = S_C;
            end
         end
         S_C: begin
            if (m_done) begin
               inner_in = 15'(SIN_B - m_prod[31:15]);
               go_in    = 1'b1;
               state_in = S_B;
            end
         end
         S_B: begin
            if (m_done) begin
               mid_in   = 16'(SIN_A - m_prod[31:15]);
               go_in    = 1'b1;
               state_in = S_A;
            end
         end
         S_A: begin
            if (m_done) begin
               sine_in  = neg_ff ? -$signed(16'(y)) : $signed(16'(y));
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      inner_ff <= inner_in;
      mid_ff   <= mid_in;
      neg_ff   <= neg_in;
      sine_ff  <= sine_in;
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         go_ff    <= go_in;
      end
   end

   assign done = done_ff;
   assign sine = sine_ff;
endmodule

// ===== rtl/tssmg_root.sv =====
// Floor square root, one result bit (two radicand bits) per cycle.
module tssmg_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tssmg_pkg::SQ_W-1:0]    radicand,
   output logic                          done,
   output logic [tssmg_pkg::ROOT_W-1:0]  root
);
   import tssmg_pkg::*;

   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] rem_ff, rem_in, rem_sh, trial;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign rem_sh = {rem_ff[ROOT_W:0], rad_ff[SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'(ROOT_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/tssmg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tssmg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tssmg_pkg::NUM_W-1:0]   numer,
   input  logic [tssmg_pkg::ROOT_W-1:0]  denom,
   output logic                          done,
   output logic [tssmg_pkg::NUM_W-1:0]   quot
);
   import tssmg_pkg::*;

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ROOT_W-1:0] den_ff, den_in;
   logic [ROOT_W:0]   rem_ff, rem_in, rem_sh;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              fits;

   assign rem_sh = {rem_ff[ROOT_W-1:0], num_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift quotient bits in behind the numerator
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'(NUM_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

// ===== rtl/tilt_shake_spin_motion_generator.sv =====
// Flow per accepted request, the two divides skipped when the sum is too short to normalize:
// twelve serial products, five sines (four 16-bit products each), the root, two divides,
// then the load of the output register.
// Throughput: one transaction at a time; the next request is taken the cycle after the result
// is handed to the output register, which waits for rsp_tready.
// Reset (synchronous): phases cleared, registers to defaults, no result pending.
module tilt_shake_spin_motion_generator #(
   parameter int unsigned PHASE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tssmg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tssmg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [15:0] dt
   input  logic                                req_tuser,   // [0] op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] gravity_x, [63:32] gravity_y, [88:64] spin_z, [113:89] spin_accel_z, zero pad
   output logic [119:0]                        rsp_tdata
);
   import tssmg_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001, ST_PH   = 16'h0002, ST_SIN  = 16'h0004, ST_K    = 16'h0008,
      ST_KC   = 16'h0010, ST_KS   = 16'h0020, ST_SQX  = 16'h0040, ST_SQY  = 16'h0080,
      ST_ROOT = 16'h0100, ST_DIVX = 16'h0200, ST_DIVY = 16'h0400, ST_GX   = 16'h0800,
      ST_GY   = 16'h1000, ST_WZ   = 16'h2000, ST_AZ   = 16'h4000, ST_OUT  = 16'h8000
   } seq_state_type;

   localparam int unsigned PW = MUL_AW + MUL_BW;

   seq_state_type state_ff, state_in;

   logic [31:0] tilt_rate_ff, shake_rate_ff, spin_rate_ff;
   logic [15:0] shake_gain_ff;
   logic [23:0] gravity_scale_ff, spin_amp_ff, alpha_amp_ff;

   logic [PHASE_BITS-1:0] tilt_ph_ff, tilt_ph_in, shake_ph_ff, shake_ph_in;
   logic [PHASE_BITS-1:0] spin_ph_ff, spin_ph_in, inc, cur_ph;
   logic [15:0]           dt_ff, dt_in;
   logic [2:0]            idx_ff, idx_in;

   logic signed [15:0] sx_ff, sx_in, cy_ff, cy_in, ss_ff, ss_in;
   logic signed [15:0] sp_ff, sp_in, cp_ff, cp_in;
   logic signed [18:0] k_ff, k_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [ROOT_W-1:0]  m_ff, m_in;
   logic [31:0]        gx_ff, gx_in, gy_ff, gy_in;
   logic [24:0]        wz_ff, wz_in, az_ff, az_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [119:0] rsp_data_ff, rsp_data_in;

   logic              mul_go_ff, mul_go_in, sin_go_ff, sin_go_in;
   logic              root_go_ff, root_go_in, div_go_ff, div_go_in;
   logic [MUL_AW-1:0] ma;
   logic [MUL_BW-1:0] mb;
   logic              m_neg, m_done;
   logic [PW-1:0]     m_prod;
   logic [47:0]       inc_ext;
   logic signed [PW:0] sval, num;
   logic [15:0]       sin_angle;
   logic              sin_done;
   logic signed [15:0] sin_val;
   logic              root_done;
   logic [ROOT_W-1:0] root_val;
   logic              div_done, div_neg;
   logic [NUM_W-1:0]  div_num, div_q;
   logic [17:0]       k_mag, ax_mag, ay_mag, sx_mag, cy_mag, ss_mag, sp_mag, cp_mag;
   logic [18:0]       q_ext;
   logic              req_acc;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_rate_ff     <= RST_TILT_RATE;
         shake_rate_ff    <= RST_SHAKE_RATE;
         spin_rate_ff     <= RST_SPIN_RATE;
         shake_gain_ff    <= RST_SHAKE_GAIN;
         gravity_scale_ff <= RST_GRAVITY_SCALE;
         spin_amp_ff      <= RST_SPIN_AMP;
         alpha_amp_ff     <= RST_ALPHA_AMP;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TILT_RATE:     tilt_rate_ff     <= csr_wdata;
            CSR_SHAKE_RATE:    shake_rate_ff    <= csr_wdata;
            CSR_SPIN_RATE:     spin_rate_ff     <= csr_wdata;
            CSR_SHAKE_GAIN:    shake_gain_ff    <= csr_wdata[15:0];
            CSR_GRAVITY_SCALE: gravity_scale_ff <= csr_wdata[23:0];
            CSR_SPIN_AMP:      spin_amp_ff      <= csr_wdata[23:0];
            CSR_ALPHA_AMP:     alpha_amp_ff     <= csr_wdata[23:0];
            default:           ;
         endcase
      end
   end

   // ---------------------------------------------------------------- units
   tssmg_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_go_ff), .a(ma), .b(mb),
      .done(m_done), .product(m_prod)
   );

   tssmg_sine u_sine (
      .clock(clock), .reset(reset), .start(sin_go_ff), .angle(sin_angle),
      .done(sin_done), .sine(sin_val)
   );

   tssmg_root u_root (
      .clock(clock), .reset(reset), .start(root_go_ff), .radicand(sq_ff),
      .done(root_done), .root(root_val)
   );

   tssmg_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff), .numer(div_num), .denom(m_ff),
      .done(div_done), .quot(div_q)
   );

   // ---------------------------------------------------------------- datapath
   assign k_mag  = k_ff[18]  ? 18'(-k_ff)  : 18'(k_ff);
   assign ax_mag = ax_ff[18] ? 18'(-ax_ff) : 18'(ax_ff);
   assign ay_mag = ay_ff[18] ? 18'(-ay_ff) : 18'(ay_ff);
   assign sx_mag = sx_ff[15] ? 18'(-sx_ff) : 18'(sx_ff);
   assign cy_mag = cy_ff[15] ? 18'(-cy_ff) : 18'(cy_ff);
   assign ss_mag = ss_ff[15] ? 18'(-ss_ff) : 18'(ss_ff);
   assign sp_mag = sp_ff[15] ? 18'(-sp_ff) : 18'(sp_ff);
   assign cp_mag = cp_ff[15] ? 18'(-cp_ff) : 18'(cp_ff);

   always_comb begin
      unique case (state_ff)
         ST_PH: begin
            unique case (idx_ff)
               3'd0:    ma = tilt_rate_ff;
               3'd1:    ma = shake_rate_ff;
               default: ma = spin_rate_ff;
            endcase
            mb = {2'b00, dt_ff}; m_neg = 1'b0;
         end
         ST_K:    begin ma = 32'(shake_gain_ff);    mb = ss_mag; m_neg = ss_ff[15]; end
         ST_KC:   begin ma = 32'(k_mag);  mb = cy_mag; m_neg = k_ff[18] ^ cy_ff[15]; end
         ST_KS:   begin ma = 32'(k_mag);  mb = sx_mag; m_neg = k_ff[18] ^ sx_ff[15]; end
         ST_SQX:  begin ma = 32'(ax_mag); mb = ax_mag; m_neg = 1'b0; end
         ST_SQY:  begin ma = 32'(ay_mag); mb = ay_mag; m_neg = 1'b0; end
         ST_GX:   begin ma = 32'(gravity_scale_ff); mb = ax_mag; m_neg = ax_ff[18]; end
         ST_GY:   begin ma = 32'(gravity_scale_ff); mb = ay_mag; m_neg = ay_ff[18]; end
         ST_WZ:   begin ma = 32'(spin_amp_ff);  mb = sp_mag; m_neg = sp_ff[15]; end
         ST_AZ:   begin ma = 32'(alpha_amp_ff); mb = cp_mag; m_neg = cp_ff[15]; end
         default: begin ma = '0; mb = '0; m_neg = 1'b0; end
      endcase
   end

   assign sval = m_neg ? -$signed({1'b0, m_prod}) : $signed({1'b0, m_prod});

   // rate*dt is in 2^-44 turn; align to 2^-48 and keep the top PHASE_BITS
   assign inc_ext = {m_prod[43:0], 4'b0000};
   assign inc     = inc_ext[47 -: PHASE_BITS];

   always_comb begin
      unique case (idx_ff)
         3'd0:    cur_ph = tilt_ph_ff;
         3'd1:    cur_ph = shake_ph_ff;
         default: cur_ph = spin_ph_ff;
      endcase
   end

   always_comb begin
      unique case (idx_ff)
         3'd0:    sin_angle = tilt_ph_ff[PHASE_BITS-1 -: 16];
         3'd1:    sin_angle = tilt_ph_ff[PHASE_BITS-1 -: 16] + 16'h4000;
         3'd2:    sin_angle = shake_ph_ff[PHASE_BITS-1 -: 16];
         3'd3:    sin_angle = spin_ph_ff[PHASE_BITS-1 -: 16];
         default: sin_angle = spin_ph_ff[PHASE_BITS-1 -: 16] + 16'h4000;
      endcase
   end

   always_comb begin
      if (state_ff == ST_KC) num = ($signed((PW+1)'(sx_ff)) <<< 15) - sval;
      else                   num = ($signed((PW+1)'(cy_ff)) <<< 15) + sval;
   end

   assign div_neg = (state_ff == ST_DIVY) ? ay_ff[18] : ax_ff[18];
   assign div_num = (state_ff == ST_DIVY) ? {ay_mag[17:0], 15'b0} : {ax_mag[17:0], 15'b0};
   assign q_ext   = {1'b0, div_q[17:0]};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      tilt_ph_in  = tilt_ph_ff;
      shake_ph_in = shake_ph_ff;
      spin_ph_in  = spin_ph_ff;
      dt_in       = dt_ff;
      idx_in      = idx_ff;
      sx_in = sx_ff; cy_in = cy_ff; ss_in = ss_ff; sp_in = sp_ff; cp_in = cp_ff;
      k_in  = k_ff;  ax_in = ax_ff; ay_in = ay_ff;
      sq_in = sq_ff; m_in  = m_ff;
      gx_in = gx_ff; gy_in = gy_ff; wz_in = wz_ff; az_in = az_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_go_in  = 1'b0;
      sin_go_in  = 1'b0;
      root_go_in = 1'b0;
      div_go_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               dt_in = req_tdata;
               if (req_tuser) begin
                  tilt_ph_in  = '0;
                  shake_ph_in = '0;
                  spin_ph_in  = '0;
               end
               idx_in    = 3'd0;
               mul_go_in = 1'b1;
               state_in  = ST_PH;
            end
         end
         ST_PH: begin
            if (m_done) begin
               unique case (idx_ff)
                  3'd0:    tilt_ph_in  = cur_ph + inc;
                  3'd1:    shake_ph_in = cur_ph + inc;
                  default: spin_ph_in  = cur_ph + inc;
               endcase
               if (idx_ff == 3'd2) begin
                  idx_in    = 3'd0;
                  sin_go_in = 1'b1;
                  state_in  = ST_SIN;
               end else begin
                  idx_in    = idx_ff + 3'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         ST_SIN: begin
            if (sin_done) begin
               unique case (idx_ff)
                  3'd0:    sx_in = sin_val;
                  3'd1:    cy_in = sin_val;
                  3'd2:    ss_in = sin_val;
                  3'd3:    sp_in = sin_val;
                  default: cp_in = sin_val;
               endcase
               if (idx_ff == 3'd4) begin
                  idx_in    = 3'd0;
                  mul_go_in = 1'b1;
                  state_in  = ST_K;
               end else begin
                  idx_in    = idx_ff + 3'd1;
                  sin_go_in = 1'b1;
               end
            end
         end
         ST_K: begin
            if (m_done) begin
               k_in      = 19'(sval >>> 14);
               mul_go_in = 1'b1;
               state_in  = ST_KC;
            end
         end
         ST_KC: begin
            if (m_done) begin
               ax_in     = 19'(num >>> 15);
               mul_go_in = 1'b1;
               state_in  = ST_KS;
            end
         end
         ST_KS: begin
            if (m_done) begin
               ay_in     = 19'(num >>> 15);
               mul_go_in = 1'b1;
               state_in  = ST_SQX;
            end
         end
         ST_SQX: begin
            if (m_done) begin
               sq_in     = m_prod[SQ_W-1:0];
               mul_go_in = 1'b1;
               state_in  = ST_SQY;
            end
         end
         ST_SQY: begin
            if (m_done) begin
               sq_in      = sq_ff + m_prod[SQ_W-1:0];
               root_go_in = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               m_in = root_val;
               // short vector: scale as it stands
               if (root_val > NORM_MIN) begin
                  div_go_in = 1'b1;
                  state_in  = ST_DIVX;
               end else begin
                  mul_go_in = 1'b1;
                  state_in  = ST_GX;
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               ax_in     = div_neg ? -$signed(q_ext) : $signed(q_ext);
               div_go_in = 1'b1;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               ay_in     = div_neg ? -$signed(q_ext) : $signed(q_ext);
               mul_go_in = 1'b1;
               state_in  = ST_GX;
            end
         end
         ST_GX: begin
            if (m_done) begin
               gx_in     = 32'(sval >>> 15);
               mul_go_in = 1'b1;
               state_in  = ST_GY;
            end
         end
         ST_GY: begin
            if (m_done) begin
               gy_in     = 32'(sval >>> 15);
               mul_go_in = 1'b1;
               state_in  = ST_WZ;
            end
         end
         ST_WZ: begin
            if (m_done) begin
               wz_in     = 25'(sval >>> 15);
               mul_go_in = 1'b1;
               state_in  = ST_AZ;
            end
         end
         ST_AZ: begin
            if (m_done) begin
               az_in    = 25'(sval >>> 15);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {6'b0, az_ff, wz_ff, gy_ff, gx_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dt_ff  <= dt_in;
      idx_ff <= idx_in;
      sx_ff <= sx_in; cy_ff <= cy_in; ss_ff <= ss_in; sp_ff <= sp_in; cp_ff <= cp_in;
      k_ff  <= k_in;  ax_ff <= ax_in; ay_ff <= ay_in;
      sq_ff <= sq_in; m_ff  <= m_in;
      gx_ff <= gx_in; gy_ff <= gy_in; wz_ff <= wz_in; az_ff <= az_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         tilt_ph_ff   <= '0;
         shake_ph_ff  <= '0;
         spin_ph_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         sin_go_ff    <= 1'b0;
         root_go_ff   <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tilt_ph_ff   <= tilt_ph_in;
         shake_ph_ff  <= shake_ph_in;
         spin_ph_ff   <= spin_ph_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_go_ff    <= mul_go_in;
         sin_go_ff    <= sin_go_in;
         root_go_ff   <= root_go_in;
         div_go_ff    <= div_go_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
